// ----- rtl/boe_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
// Depends on nothing; used by boe_cell and bounded_ordered_list_engine.
package boe_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request modes.
    localparam logic [2:0] MODE_INSERT_FRONT = 3'd0;
    localparam logic [2:0] MODE_REMOVE_FRONT = 3'd1;
    localparam logic [2:0] MODE_SEARCH       = 3'd2;
    localparam logic [2:0] MODE_REMOVE_VALUE = 3'd3;
    localparam logic [2:0] MODE_REMOVE_LAST  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Cell operations broadcast along the chain.
    localparam logic [1:0] CELL_HOLD      = 2'd0;
    localparam logic [1:0] CELL_SHIFT_IN  = 2'd1;
    localparam logic [1:0] CELL_SHIFT_OUT = 2'd2;
    localparam logic [1:0] CELL_DEL_MATCH = 2'd3;

    typedef struct packed {
        logic        [2:0]  mode;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_position;
        logic [4:0] entry_count;
        logic       list_empty;
    } rsp_t;

    typedef struct packed {
        logic        [1:0]  op;
        logic signed [31:0] value;
    } cell_cmd_t;

endpackage

// ----- rtl/boe_cell.sv -----
// One list cell: holds a single entry, compares it to the broadcast value and
// shifts toward either neighbor. Depends on boe_pkg.
module boe_cell (
    input  logic                      aclk,
    input  boe_pkg::cell_cmd_t        cmd,
    input  logic signed [31:0]        left_data,
    input  logic signed [31:0]        right_data,
    input  logic                      occupied,
    input  logic                      seen_in,
    output logic signed [31:0]        entry,
    output logic                      seen_out,
    output logic                      hit
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               match;

    assign match    = occupied && (entry_reg == cmd.value);
    assign hit      = match && !seen_in;
    assign seen_out = seen_in || match;
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            boe_pkg::CELL_SHIFT_IN:  entry_next = left_data;
            boe_pkg::CELL_SHIFT_OUT: entry_next = right_data;
            boe_pkg::CELL_DEL_MATCH: begin
                // Cells at or behind the first match close the gap.
                if (seen_out) begin
                    entry_next = right_data;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine: request register, cell chain
// control, occupancy count and result register. Depends on boe_pkg, boe_cell.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit values with
// position 0 at the front, held in a row of cells that each own one entry. A
// request beat is taken into a request register and executed once the result
// register is free or draining, when every cell compares its entry against the
// request value and shifts toward a neighbor at once; the result beat is registered
// in the result register and offered from there. A new request is accepted in every
// cycle as long as results are taken, so the sustained rate is one beat per cycle,
// and the request register lets one more request in while a result waits. The
// execute cycle's length is set by the first-match flag that ripples through all
// cells. Inserting into a full list reports status full, and any removal or search
// on an empty list reports status empty; both leave the list unchanged. Unused mode
// codes change nothing and report done. Found position keeps only its low bits when
// CAPACITY exceeds sixteen, and entry count when CAPACITY exceeds thirty-one.
module bounded_ordered_list_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  boe_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output boe_pkg::rsp_t m_rsp
);

    localparam int CAP   = boe_pkg::CAPACITY;
    localparam int IDX_W = boe_pkg::IDX_W;
    localparam int CNT_W = boe_pkg::CNT_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAP);

    // Request stage.
    boe_pkg::req_t    req_reg;
    logic             req_valid_reg;
    logic             req_valid_next;

    // Result stage.
    boe_pkg::rsp_t    rsp_reg;
    boe_pkg::rsp_t    rsp_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    // Occupancy.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             exec;
    logic             list_is_empty;
    logic             list_is_full;
    logic             any_hit;
    logic [IDX_W-1:0] hit_pos;
    logic [1:0]       cell_op;
    logic [1:0]       status;
    logic [IDX_W-1:0] report_pos;

    boe_pkg::cell_cmd_t cmd;

    logic signed [31:0] cell_entry [CAP];
    logic               cell_hit   [CAP];
    logic               seen       [CAP+1];

    // The request is executed when the result register is free or draining.
    assign exec    = req_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || exec;
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    assign list_is_empty = (count_reg == '0);
    assign list_is_full  = (count_reg == FULL_COUNT);

    assign cmd.op    = exec ? cell_op : boe_pkg::CELL_HOLD;
    assign cmd.value = req_reg.value;

    // The cell chain. The first-match flag enters at the front and ripples back.
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);

        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        if (i == 0) begin : g_front
            assign left_data = req_reg.value;
        end else begin : g_inner_left
            assign left_data = cell_entry[i-1];
        end

        if (i == CAP - 1) begin : g_back
            assign right_data = cell_entry[i];
        end else begin : g_inner_right
            assign right_data = cell_entry[i+1];
        end

        boe_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .occupied   (CELL_IDX < count_reg),
            .seen_in    (seen[i]),
            .entry      (cell_entry[i]),
            .seen_out   (seen[i+1]),
            .hit        (cell_hit[i])
        );
    end

    assign any_hit = seen[CAP];

    // At most one cell flags the first match, so its index is an OR of all.
    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < CAP; i++) begin
            if (cell_hit[i]) begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    // Request decode.
    always_comb begin
        cell_op    = boe_pkg::CELL_HOLD;
        status     = boe_pkg::ST_DONE;
        report_pos = '0;
        count_next = count_reg;
        unique case (req_reg.mode)
            boe_pkg::MODE_INSERT_FRONT: begin
                if (list_is_full) begin
                    status = boe_pkg::ST_FULL;
                end else begin
                    cell_op    = boe_pkg::CELL_SHIFT_IN;
                    count_next = count_reg + 1'b1;
                end
            end
            boe_pkg::MODE_REMOVE_FRONT: begin
                if (list_is_empty) begin
                    status = boe_pkg::ST_EMPTY;
                end else begin
                    cell_op    = boe_pkg::CELL_SHIFT_OUT;
                    count_next = count_reg - 1'b1;
                end
            end
            boe_pkg::MODE_SEARCH: begin
                if (list_is_empty) begin
                    status = boe_pkg::ST_EMPTY;
                end else if (!any_hit) begin
                    status = boe_pkg::ST_NOT_FOUND;
                end else begin
                    report_pos = hit_pos;
                end
            end
            boe_pkg::MODE_REMOVE_VALUE: begin
                if (list_is_empty) begin
                    status = boe_pkg::ST_EMPTY;
                end else if (!any_hit) begin
                    status = boe_pkg::ST_NOT_FOUND;
                end else begin
                    cell_op    = boe_pkg::CELL_DEL_MATCH;
                    count_next = count_reg - 1'b1;
                end
            end
            boe_pkg::MODE_REMOVE_LAST: begin
                // Dropping the back entry only shortens the count.
                if (list_is_empty) begin
                    status = boe_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                status = boe_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        rsp_next.status         = status;
        rsp_next.found_position = 4'(report_pos);
        rsp_next.entry_count    = 5'(count_next);
        rsp_next.list_empty     = (count_next == '0);
    end

    always_comb begin
        req_valid_next = req_valid_reg;
        if (s_valid && s_ready) begin
            req_valid_next = 1'b1;
        end else if (exec) begin
            req_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            count_reg     <= '0;
        end else begin
            req_valid_reg <= req_valid_next;
            m_valid_reg   <= m_valid_next;
            if (exec) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
        if (exec) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- tb/tb_bounded_ordered_list_engine.sv -----
// Self-checking testbench for bounded_ordered_list_engine: predicts every result
// from a shadow list, checks each result beat field by field, and stresses the handshakes.
// Depends on boe_pkg and the bounded_ordered_list_engine RTL.
module tb_bounded_ordered_list_engine;

    // Mode codes that the engine does not use; it must treat them as no-ops.
    localparam logic [2:0] MODE_FIRST_SPARE = 3'd5;
    localparam logic [2:0] MODE_LAST_SPARE  = 3'd7;

    localparam int RANDOM_ITEMS  = 1200;
    localparam int CALM_TAIL     = 150;   // No idling on either side for the last beats.
    localparam int HOLD_AT_ITEM  = 400;   // Input beat count that starts the long output stall.
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_CYCLES  = 8;
    localparam int TIMEOUT_UNITS = 4_000_000;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    boe_pkg::req_t  s_req   = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    boe_pkg::rsp_t  m_rsp;

    // Stimulus backlog, the shadow copy of the list, and the results it predicts.
    boe_pkg::req_t       req_backlog[$];
    logic signed [31:0]  list_shadow[$];
    boe_pkg::rsp_t       predicted_rsps[$];
    logic signed [31:0]  value_pool[8];

    int unsigned total_items = 0;
    int unsigned sent_count  = 0;
    int unsigned mismatches  = 0;
    int unsigned src_gap     = 0;
    int unsigned sink_gap    = 0;
    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;

    bounded_ordered_list_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one request to the shadow list and returns the result the engine owes.
    // Searches scan from the front, so the first of several equal values wins.
    function automatic boe_pkg::rsp_t predict_list_op(input boe_pkg::req_t r);
        boe_pkg::rsp_t rsp;
        int            hit;
        rsp = '0;
        rsp.status = boe_pkg::ST_DONE;
        hit = -1;
        case (r.mode)
            boe_pkg::MODE_INSERT_FRONT: begin
                if (list_shadow.size() >= boe_pkg::CAPACITY) begin
                    rsp.status = boe_pkg::ST_FULL;
                end else begin
                    list_shadow.push_front(r.value);
                end
            end
            boe_pkg::MODE_REMOVE_FRONT: begin
                if (list_shadow.size() == 0) begin
                    rsp.status = boe_pkg::ST_EMPTY;
                end else begin
                    void'(list_shadow.pop_front());
                end
            end
            boe_pkg::MODE_SEARCH, boe_pkg::MODE_REMOVE_VALUE: begin
                if (list_shadow.size() == 0) begin
                    rsp.status = boe_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_shadow.size() && hit < 0; i++) begin
                        if (list_shadow[i] == r.value) hit = i;
                    end
                    if (hit < 0) begin
                        rsp.status = boe_pkg::ST_NOT_FOUND;
                    end else if (r.mode == boe_pkg::MODE_SEARCH) begin
                        rsp.found_position = 4'(hit);
                    end else begin
                        list_shadow.delete(hit);
                    end
                end
            end
            boe_pkg::MODE_REMOVE_LAST: begin
                if (list_shadow.size() == 0) begin
                    rsp.status = boe_pkg::ST_EMPTY;
                end else begin
                    void'(list_shadow.pop_back());
                end
            end
            default: ;
        endcase
        rsp.entry_count = 5'(list_shadow.size());
        rsp.list_empty  = (list_shadow.size() == 0);
        return rsp;
    endfunction

    // Mostly values from a small pool so that searches and removals find matches;
    // the rest are fully random to toggle every bit.
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) < 7) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    task automatic queue_req(input logic [2:0] mode, input logic signed [31:0] value);
        boe_pkg::req_t r;
        r.mode  = mode;
        r.value = value;
        req_backlog.push_back(r);
    endtask

    // Idling is allowed except in the final stretch and in a quiet window every 300 beats.
    function automatic bit idling_allowed();
        return (sent_count + CALM_TAIL < total_items) && ((sent_count % 300) >= 50);
    endfunction

    // Request driver. A beat that was accepted at this edge goes through the
    // predictor here, so the expectation always precedes its result beat.
    always @(posedge aclk) begin
        bit busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                predicted_rsps.push_back(predict_list_op(s_req));
                sent_count <= sent_count + 1;
                busy = 1'b0;
            end
            if (!busy) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (req_backlog.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (idling_allowed() && hold_left == 0 && $urandom_range(0, 7) == 0) begin
                    src_gap <= $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_req   <= req_backlog.pop_front();
                end
            end
        end
    end

    // Long output stall, counted here, while the driver keeps offering beats.
    // The engine must fill its registers and drop s_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && sent_count >= HOLD_AT_ITEM) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor and ready generator.
    always @(posedge aclk) begin
        boe_pkg::rsp_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_rsps.size() == 0) begin
                    $error("unexpected result beat: %p", m_rsp);
                    mismatches++;
                end else begin
                    want = predicted_rsps.pop_front();
                    if (m_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_rsp.status);
                        mismatches++;
                    end
                    if (m_rsp.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, actual %0d",
                               want.found_position, m_rsp.found_position);
                        mismatches++;
                    end
                    if (m_rsp.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, m_rsp.entry_count);
                        mismatches++;
                    end
                    if (m_rsp.list_empty !== want.list_empty) begin
                        $error("list_empty: expected %0d, actual %0d",
                               want.list_empty, m_rsp.list_empty);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 6);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [2:0]         shrink_modes[4];
        int unsigned        seg_left;
        int unsigned        insert_pct;
        int unsigned        roll;
        logic [2:0]         mode;
        logic signed [31:0] fill_val;

        shrink_modes = '{boe_pkg::MODE_REMOVE_FRONT, boe_pkg::MODE_SEARCH,
                         boe_pkg::MODE_REMOVE_VALUE, boe_pkg::MODE_REMOVE_LAST};
        value_pool   = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1,
                         $urandom, $urandom, $urandom};

        // Every operation that needs an entry, run on the empty list, then a spare code.
        queue_req(boe_pkg::MODE_REMOVE_FRONT, 32'sd0);
        queue_req(boe_pkg::MODE_SEARCH, 32'sd0);
        queue_req(boe_pkg::MODE_REMOVE_VALUE, 32'sd0);
        queue_req(boe_pkg::MODE_REMOVE_LAST, 32'sd0);
        queue_req(MODE_FIRST_SPARE, 32'sh7fff_ffff);

        // Fill to capacity with the extremes first and one duplicated value.
        for (int i = 0; i < boe_pkg::CAPACITY; i++) begin
            case (i)
                0:       fill_val = 32'sh8000_0000;
                1:       fill_val = 32'sh7fff_ffff;
                2:       fill_val = 32'sd0;
                3:       fill_val = -32'sd1;
                4, 9:    fill_val = 32'sd77;
                default: fill_val = 32'(i * 1000003);
            endcase
            queue_req(boe_pkg::MODE_INSERT_FRONT, fill_val);
        end
        // Insert into a full list, then searches for the back entry and for the
        // duplicated value (the newer copy must win), and removal of an absent value.
        queue_req(boe_pkg::MODE_INSERT_FRONT, 32'sd5);
        queue_req(boe_pkg::MODE_SEARCH, 32'sh8000_0000);
        queue_req(boe_pkg::MODE_SEARCH, 32'sd77);
        queue_req(boe_pkg::MODE_REMOVE_VALUE, 32'sd12345);
        queue_req(boe_pkg::MODE_REMOVE_VALUE, 32'sh7fff_ffff);
        queue_req(boe_pkg::MODE_REMOVE_FRONT, 32'sd0);
        queue_req(boe_pkg::MODE_REMOVE_LAST, 32'sd0);
        queue_req(MODE_LAST_SPARE, -32'sd1);

        // Random part: segments that lean toward growing or shrinking, so the
        // list keeps swinging between empty and full.
        seg_left   = 0;
        insert_pct = 0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(30, 120);
                insert_pct = $urandom_range(0, 1) ? 65 : 25;
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                mode = 3'($urandom_range(MODE_FIRST_SPARE, MODE_LAST_SPARE));
            end else if (roll < 3 + insert_pct) begin
                mode = boe_pkg::MODE_INSERT_FRONT;
            end else begin
                mode = shrink_modes[$urandom_range(0, 3)];
            end
            queue_req(mode, pick_value());
        end
        total_items = req_backlog.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (req_backlog.size() != 0 || s_valid || predicted_rsps.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (predicted_rsps.size() != 0) begin
            $error("%0d results never arrived", predicted_rsps.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_bounded_ordered_list_engine: PASS");
        end else begin
            $display("tb_bounded_ordered_list_engine: FAIL");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("tb_bounded_ordered_list_engine: FAIL");
        $finish;
    end

endmodule
